### rtl/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg: shared types and constants for the checked integer ALU
// Opcodes, status codes and the beat record that moves along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none
package cia_pkg;
  localparam int unsigned WordW  = 32;
  localparam int unsigned IdxW   = 6;   // bit counter, holds 0..WordW
  localparam int unsigned NCells = 32;  // one quotient/multiplier bit per cell

  localparam logic [3:0] OpEq = 4'd0, OpLt = 4'd1, OpLe = 4'd2, OpGt = 4'd3,
                         OpGe = 4'd4, OpNot = 4'd5, OpAnd = 4'd6, OpOr = 4'd7,
                         OpXor = 4'd8, OpShift = 4'd9, OpAbs = 4'd10, OpAdd = 4'd11,
                         OpSub = 4'd12, OpMul = 4'd13, OpMod = 4'd14, OpNeg = 4'd15;

  localparam logic [1:0] StOk = 2'd0, StOvf = 2'd1, StZdiv = 2'd2;

  // Data carried between neighbor cells.
  typedef struct packed {
    logic              vld;
    logic [3:0]        kind;
    logic [WordW-1:0]  res;     // result for non-iterative opcodes
    logic [1:0]        st;
    logic [WordW-1:0]  ma;      // |a|: shifted out MSB-first for mod, multiplier for mul
    logic [WordW-1:0]  mb;      // |b|
    logic [WordW:0]    acc;     // partial remainder (mod)
    logic [2*WordW-1:0] prod;   // partial product (mul)
    logic              sa;      // sign of a
    logic              sb;      // sign of b
  } cell_t;
endpackage
`default_nettype wire

### rtl/checked_integer_alu.sv
// ----------------------------------------------------------------------------
// checked_integer_alu: 32-bit integer ALU with overflow and zero-divisor flags
// Sixteen opcodes; mul and mod run through a chain of bit cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per beat: kind, operand_a, operand_b.
//   m_axis returns one beat per operation: result_value and status,
//   in issue order.
//   Every opcode passes through a decode cell, 32 bit cells
//   (one bit of |a| per cell for the remainder and the product), and
//   an output cell. A new beat is taken in every cycle unless the chain holds.
//   The whole chain advances together; when m_axis stalls with a valid
//   beat at the output, the chain holds and s_axis_tready drops.
//   Empty slots travel with the chain; only an empty output slot lets
//   the chain advance while m_axis_tready is low.
//   Reset clears all valid bits; no result is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module checked_integer_alu import cia_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // kind[3:0], operand_a[35:4], operand_b[67:36]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata    // result_value[31:0], status[33:32]
);
  cell_t chain [NCells+1];
  logic  en;
  logic [WordW-1:0] res;
  logic [1:0] st;

  // advance when the output is free
  assign en = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = en;

  cia_front u_front (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i (s_axis_tvalid),
    .kind_i(s_axis_tdata[3:0]),
    .a_i   (s_axis_tdata[35:4]),
    .b_i   (s_axis_tdata[67:36]),
    .cell_o(chain[0])
  );

  for (genvar g = 0; g < NCells; g++) begin : g_cell
    cia_cell u_cell (.clk_i, .rst_ni, .en_i(en), .cell_i(chain[g]), .cell_o(chain[g+1]));
  end

  cia_back u_back (
    .clk_i, .rst_ni, .en_i(en), .cell_i(chain[NCells]),
    .vld_o(m_axis_tvalid), .res_o(res), .st_o(st)
  );

  assign m_axis_tdata = {6'd0, st, res};

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output beat changed while stalled");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("input blocked with empty output");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[39:34] == '0)) else $error("padding set");
`endif
endmodule
`default_nettype wire

### rtl/cia_front.sv
// ----------------------------------------------------------------------------
// cia_front: first cell
// Decodes the opcode, computes the non-iterative opcodes and the magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none
module cia_front import cia_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               vld_i,
  input  wire logic [3:0]         kind_i,
  input  wire logic [WordW-1:0]   a_i,
  input  wire logic [WordW-1:0]   b_i,
  output cell_t                   cell_o
);
  cell_t c_d, c_q;
  logic signed [WordW-1:0] sa, sb;
  logic [WordW-1:0] sum, dif;
  logic [WordW-1:0] nb, shl, shr;
  logic lt, gt, eq;

  always_comb begin
    sa  = $signed(a_i);
    sb  = $signed(b_i);
    lt  = sa < sb;
    gt  = sb < sa;
    eq  = a_i == b_i;
    sum = a_i + b_i;
    dif = a_i - b_i;
    nb  = WordW'(0) - b_i;
    shl = (b_i >= WordW'(WordW)) ? '0 : a_i << b_i[IdxW-1:0];
    shr = (nb  >= WordW'(WordW)) ? '0 : a_i >> nb[IdxW-1:0];
    c_d      = '0;
    c_d.vld  = vld_i;
    c_d.kind = kind_i;
    c_d.st   = StOk;
    c_d.sa   = a_i[WordW-1];
    c_d.sb   = b_i[WordW-1];
    c_d.ma   = a_i[WordW-1] ? WordW'(0) - a_i : a_i;
    c_d.mb   = b_i[WordW-1] ? nb : b_i;
    case (kind_i)
      OpEq:    c_d.res = WordW'(eq);
      OpLt:    c_d.res = WordW'(lt);
      OpLe:    c_d.res = WordW'(!gt);
      OpGt:    c_d.res = WordW'(gt);
      OpGe:    c_d.res = WordW'(!lt);
      OpNot:   c_d.res = ~a_i;
      OpAnd:   c_d.res = a_i & b_i;
      OpOr:    c_d.res = a_i | b_i;
      OpXor:   c_d.res = a_i ^ b_i;
      OpShift: c_d.res = (!b_i[WordW-1] && b_i != '0) ? shl : shr;
      OpAbs:   c_d.res = a_i[WordW-1] ? WordW'(0) - a_i : a_i;
      OpAdd: begin
        c_d.res = sum;
        if ((a_i[WordW-1] ^ sum[WordW-1]) & (b_i[WordW-1] ^ sum[WordW-1])) begin
          c_d.res = '0;
          c_d.st  = StOvf;
        end
      end
      OpSub: begin
        c_d.res = dif;
        if ((a_i[WordW-1] ^ b_i[WordW-1]) & (a_i[WordW-1] ^ dif[WordW-1])) begin
          c_d.res = '0;
          c_d.st  = StOvf;
        end
      end
      OpNeg:   c_d.res = WordW'(0) - a_i;
      default: c_d.res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
    end else if (en_i) begin
      c_q <= c_d;
    end
  end
  assign cell_o = c_q;
endmodule
`default_nettype wire

### rtl/cia_cell.sv
// ----------------------------------------------------------------------------
// cia_cell: one step of the shared iterative chain
// Handles one bit of |a|: a restoring remainder step and a shift-add step.
// ----------------------------------------------------------------------------
`default_nettype none
module cia_cell import cia_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  cell_t      cell_i,
  output cell_t      cell_o
);
  cell_t c_d, c_q;
  logic [WordW:0] sh, tr;

  always_comb begin
    c_d = cell_i;
    // remainder: bring in next bit of |a| (MSB first)
    sh = {cell_i.acc[WordW-1:0], cell_i.ma[WordW-1]};
    tr = sh - {1'b0, cell_i.mb};
    c_d.acc = tr[WordW] ? sh : tr;
    // product: add |b| at this bit weight (same MSB-first order)
    c_d.prod = {cell_i.prod[2*WordW-2:0], 1'b0} +
               (cell_i.ma[WordW-1] ? {{WordW{1'b0}}, cell_i.mb} : '0);
    c_d.ma = {cell_i.ma[WordW-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
    end else if (en_i) begin
      c_q <= c_d;
    end
  end
  assign cell_o = c_q;
endmodule
`default_nettype wire

### rtl/cia_back.sv
// ----------------------------------------------------------------------------
// cia_back: last cell
// Applies signs and checks to mul and mod, selects the final result.
// ----------------------------------------------------------------------------
`default_nettype none
module cia_back import cia_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  cell_t                  cell_i,
  output logic                   vld_o,
  output logic [WordW-1:0]       res_o,
  output logic [1:0]             st_o
);
  logic             vld_q;
  logic [WordW-1:0] res_d, res_q;
  logic [1:0]       st_d, st_q;
  logic [WordW-1:0] rem;

  always_comb begin
    res_d = cell_i.res;
    st_d  = cell_i.st;
    rem   = cell_i.acc[WordW-1:0];
    if (cell_i.kind == OpMul) begin
      if (cell_i.prod[2*WordW-1:WordW-1] != '0) begin
        res_d = '0;
        st_d  = StOvf;
      end else begin
        res_d = (cell_i.sa ^ cell_i.sb) ? WordW'(0) - cell_i.prod[WordW-1:0]
                                        : cell_i.prod[WordW-1:0];
      end
    end else if (cell_i.kind == OpMod) begin
      if (cell_i.mb == '0) begin
        res_d = '0;
        st_d  = StZdiv;
      end else begin
        res_d = cell_i.sa ? WordW'(0) - rem : rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= cell_i.vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
      st_q  <= st_d;
    end
  end
  assign vld_o = vld_q;
  assign res_o = res_q;
  assign st_o  = st_q;

`ifndef SYNTHESIS
  a_st_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (st_q != 2'd3)) else $error("bad status");
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && st_q != StOk) |-> (res_q == '0)) else $error("flagged result not zero");
  a_zdiv_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && cell_i.vld && cell_i.kind != OpMod) |=> (st_q != StZdiv))
    else $error("zero divisor outside mod");
`endif
endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the checked integer ALU
// Drives operation beats with random gaps, predicts each result and status,
// and compares every output beat in order against the predicted queue.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import cia_pkg::*;

  // kind in the lowest bits, as on s_axis_tdata
  typedef struct packed {
    logic [31:0] op_b;
    logic [31:0] op_a;
    logic [3:0]  kind;
  } alu_op_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  st;
  } alu_res_t;

  localparam int Latency = 34;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  alu_op_t  pending_ops[$];
  alu_res_t expected_results[$];
  int       error_count = 0;
  int       send_wait = 0;
  int       recv_wait = 0;
  logic     hold_off = 1'b0;

  checked_integer_alu uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic alu_res_t compute_alu(alu_op_t op);
    alu_res_t          r;
    logic signed [31:0] a, b;
    logic signed [63:0] wide;
    logic [31:0]       ma, mb, rem;
    logic [32:0]       cnt;
    a = op.op_a;
    b = op.op_b;
    r.st = StOk;
    r.value = '0;
    case (op.kind)
      OpEq: r.value = 32'(a == b);
      OpLt: r.value = 32'(a < b);
      OpLe: r.value = 32'(a <= b);
      OpGt: r.value = 32'(a > b);
      OpGe: r.value = 32'(a >= b);
      OpNot: r.value = ~a;
      OpAnd: r.value = a & b;
      OpOr: r.value = a | b;
      OpXor: r.value = a ^ b;
      OpShift: begin
        if (b > 0) r.value = (b >= 32) ? '0 : (a << b[4:0]);
        else begin
          cnt = -{b[31], b};
          r.value = (cnt >= 32) ? '0 : (a >> cnt[4:0]);
        end
      end
      OpAbs: r.value = a[31] ? -a : a;
      OpAdd, OpSub: begin
        wide = (op.kind == OpAdd) ? (64'(a) + 64'(b)) : (64'(a) - 64'(b));
        if (wide > 64'sd2147483647 || wide < -64'sd2147483648) r.st = StOvf;
        else r.value = wide[31:0];
      end
      OpMul: begin
        wide = 64'(a) * 64'(b);
        // magnitude 2^31 or more is an overflow, the most negative value too
        if (wide > 64'sd2147483647 || wide < -64'sd2147483647) r.st = StOvf;
        else r.value = wide[31:0];
      end
      OpMod: begin
        if (b == 0) r.st = StZdiv;
        else begin
          ma = a[31] ? -a : a;
          mb = b[31] ? -b : b;
          rem = ma % mb;
          r.value = a[31] ? -rem : rem;
        end
      end
      default: r.value = -a;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return 32'($signed($urandom_range(0, 80)) - 40);
      4: return 32'($urandom_range(0, 65535)) - 32'd32768;
      default: return $urandom;
    endcase
  endfunction

  // driver: present head of queue, then gap
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(compute_alu(alu_op_t'(s_axis_tdata[67:0])));
        void'(pending_ops.pop_front());
        send_wait <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 11) : 0;
        if (pending_ops.size() > 0 && send_wait == 0 && $urandom_range(0, 3) != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {4'b0, pending_ops[0]};
        end else s_axis_tvalid <= 1'b0;
      end else if (!s_axis_tvalid) begin
        if (send_wait > 0) send_wait <= send_wait - 1;
        else if (pending_ops.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {4'b0, pending_ops[0]};
        end
      end
    end
  end

  // monitor: compare each output beat, stall at random
  always @(posedge clk_i) begin
    alu_res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result beat %h at %0t", m_axis_tdata, $realtime);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[31:0] !== want.value)
            report_mismatch("result_value", m_axis_tdata[31:0], want.value);
          if (m_axis_tdata[33:32] !== want.st)
            report_mismatch("status", 32'(m_axis_tdata[33:32]), 32'(want.st));
        end
      end
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        recv_wait <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 11) : 0;
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end else if (recv_wait > 0) begin
        recv_wait <= recv_wait - 1;
        m_axis_tready <= 1'b0;
      end else m_axis_tready <= 1'b1;
    end
  end

  // long receiver stall: let the chain fill and stall input
  initial begin
    wait (rst_ni);
    repeat (200) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (150) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    alu_op_t op;
    for (int k = 0; k < 16; k++) begin
      pending_ops.push_back('{kind: 4'(k), op_a: 32'h8000_0000, op_b: 32'hffff_ffff});
    end
    pending_ops.push_back('{kind: OpMod, op_a: 32'd7, op_b: 32'd0});
    pending_ops.push_back('{kind: OpMod, op_a: 32'hffff_fff9, op_b: 32'd2});
    pending_ops.push_back('{kind: OpMul, op_a: 32'h8000_0000, op_b: 32'd1});
    pending_ops.push_back('{kind: OpMul, op_a: 32'h0001_0000, op_b: 32'h0000_8000});
    pending_ops.push_back('{kind: OpShift, op_a: 32'hffff_ffff, op_b: 32'd32});
    pending_ops.push_back('{kind: OpShift, op_a: 32'hffff_ffff, op_b: 32'hffff_ffe1});
    pending_ops.push_back('{kind: OpShift, op_a: 32'h8000_0000, op_b: 32'd0});
    pending_ops.push_back('{kind: OpAdd, op_a: 32'h7fff_ffff, op_b: 32'd1});
    pending_ops.push_back('{kind: OpSub, op_a: 32'h8000_0000, op_b: 32'd1});
    for (int n = 0; n < 1850; n++) begin
      op.kind = 4'($urandom_range(0, 15));
      op.op_a = pick_operand();
      op.op_b = ($urandom_range(0, 4) == 0) ? op.op_a : pick_operand();
      if (op.kind == OpShift && $urandom_range(0, 1)) op.op_b = 32'($urandom_range(0, 80)) - 40;
      pending_ops.push_back(op);
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_ops.size() == 0);
    wait (expected_results.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (error_count == 0) $display("checked_integer_alu regression: pass");
    else $display("checked_integer_alu regression: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("checked_integer_alu regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
rtl/cia_pkg.sv
rtl/cia_front.sv
rtl/cia_cell.sv
rtl/cia_back.sv
rtl/checked_integer_alu.sv
test/testbench.sv
